// ----- rtl/rvg_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rvg_pkg: shared types and constants of the RGB565 vertical gradient unit
// Register indexes, channel numbering and the record that travels down the
// divider chain next to each row.
// ----------------------------------------------------------------------------
package rvg_pkg;

   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int COLOR_W     = 16;
   localparam int COUNT_W     = 11;
   localparam int ROW_W       = 10;
   localparam int CHAN_W      = 6;
   localparam int QUO_W       = 6;
   localparam int NUM_CHAN    = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_TOP_COLOR    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BOTTOM_COLOR = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FILL_WIDTH   = 2'd3;

   localparam int CH_RED   = 0;
   localparam int CH_GREEN = 1;
   localparam int CH_BLUE  = 2;

   localparam logic [4:0] R_MASK = 5'h1F;
   localparam logic [5:0] G_MASK = 6'h3F;
   localparam logic [4:0] B_MASK = 5'h1F;

   typedef struct packed {
      logic [COLOR_W-1:0] top_color;
      logic [COLOR_W-1:0] bottom_color;
      logic [COUNT_W-1:0] row_count;
      logic [COUNT_W-1:0] fill_width;
   } cfg_type;

   typedef struct packed {
      logic                              row_ok;
      logic [NUM_CHAN-1:0]               neg;
      logic [NUM_CHAN-1:0][CHAN_W-1:0]   base;
      logic [NUM_CHAN-1:0][QUO_W-1:0]    quo;
   } lane_type;

endpackage
`default_nettype wire

// ----- rtl/rvg_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rvg_front: input stage of the gradient pipeline
// Unpacks both colours, forms the channel differences and their products
// with the row index, and works out the clamped height, divisor and row check.
// ----------------------------------------------------------------------------
module rvg_front #(
   parameter int MAX_ROWS = 1024,
   parameter int DEN_W    = 10,
   parameter int REM_W    = 16
) (
   input  wire                                      clock,
   input  wire                                      reset,
   input  wire                                      advance,
   input  wire rvg_pkg::cfg_type                    cfg,
   input  wire                                      in_valid,
   input  wire [rvg_pkg::ROW_W-1:0]                 in_row,
   output logic                                     out_valid,
   output logic [DEN_W-1:0]                         out_den,
   output logic [rvg_pkg::NUM_CHAN-1:0][REM_W-1:0]  out_rem,
   output rvg_pkg::lane_type                        out_lane
);

   localparam int HGT_W = ($clog2(MAX_ROWS + 1) > rvg_pkg::COUNT_W) ?
                          $clog2(MAX_ROWS + 1) : rvg_pkg::COUNT_W;
   localparam int PROD_W = rvg_pkg::CHAN_W + rvg_pkg::ROW_W;

   logic                                     valid_ff;
   logic [DEN_W-1:0]                         den_ff,  den_in;
   logic [rvg_pkg::NUM_CHAN-1:0][REM_W-1:0]  rem_ff,  rem_in;
   rvg_pkg::lane_type                        lane_ff, lane_in;

   logic [HGT_W-1:0]                                 height;
   logic [rvg_pkg::NUM_CHAN-1:0][rvg_pkg::CHAN_W-1:0] top_ch, bot_ch;
   logic [rvg_pkg::NUM_CHAN-1:0][rvg_pkg::CHAN_W:0]   diff;
   logic [rvg_pkg::NUM_CHAN-1:0][rvg_pkg::CHAN_W-1:0] mag;
   logic [PROD_W-1:0]                                 prod [rvg_pkg::NUM_CHAN];

   always_comb begin
      top_ch[rvg_pkg::CH_RED]   = {1'b0, cfg.top_color[15:11]};
      top_ch[rvg_pkg::CH_GREEN] = cfg.top_color[10:5];
      top_ch[rvg_pkg::CH_BLUE]  = {1'b0, cfg.top_color[4:0]};
      bot_ch[rvg_pkg::CH_RED]   = {1'b0, cfg.bottom_color[15:11]};
      bot_ch[rvg_pkg::CH_GREEN] = cfg.bottom_color[10:5];
      bot_ch[rvg_pkg::CH_BLUE]  = {1'b0, cfg.bottom_color[4:0]};

      // A height above the supported maximum is clamped to it.
      if (HGT_W'(cfg.row_count) > HGT_W'(MAX_ROWS)) begin
         height = HGT_W'(MAX_ROWS);
      end else begin
         height = HGT_W'(cfg.row_count);
      end

      if (height > HGT_W'(1)) begin
         den_in = DEN_W'(height - HGT_W'(1));
      end else begin
         den_in = DEN_W'(1);
      end

      lane_in.row_ok = (height != '0) && (cfg.fill_width != '0) &&
                       (HGT_W'(in_row) < height);

      for (int c = 0; c < rvg_pkg::NUM_CHAN; c++) begin
         diff[c] = {1'b0, bot_ch[c]} - {1'b0, top_ch[c]};
         lane_in.neg[c]  = diff[c][rvg_pkg::CHAN_W];
         mag[c]          = diff[c][rvg_pkg::CHAN_W] ?
                           rvg_pkg::CHAN_W'(-diff[c]) : diff[c][rvg_pkg::CHAN_W-1:0];
         prod[c]         = PROD_W'(mag[c]) * PROD_W'(in_row);
         rem_in[c]       = REM_W'(prod[c]);
         lane_in.base[c] = top_ch[c];
         lane_in.quo[c]  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         den_ff  <= den_in;
         rem_ff  <= rem_in;
         lane_ff <= lane_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_den   = den_ff;
   assign out_rem   = rem_ff;
   assign out_lane  = lane_ff;

endmodule
`default_nettype wire

// ----- rtl/rvg_div_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rvg_div_cell: one restoring division step for all three channels
// Compares each partial remainder with the divisor shifted into place,
// subtracts when it fits and shifts one quotient bit in.
// ----------------------------------------------------------------------------
module rvg_div_cell #(
   parameter int DEN_W = 10,
   parameter int REM_W = 16,
   parameter int SHIFT = 0
) (
   input  wire                                      clock,
   input  wire                                      reset,
   input  wire                                      advance,
   input  wire                                      in_valid,
   input  wire [DEN_W-1:0]                          in_den,
   input  wire [rvg_pkg::NUM_CHAN-1:0][REM_W-1:0]   in_rem,
   input  wire rvg_pkg::lane_type                   in_lane,
   output logic                                     out_valid,
   output logic [DEN_W-1:0]                         out_den,
   output logic [rvg_pkg::NUM_CHAN-1:0][REM_W-1:0]  out_rem,
   output rvg_pkg::lane_type                        out_lane
);

   logic                                     valid_ff;
   logic [DEN_W-1:0]                         den_ff;
   logic [rvg_pkg::NUM_CHAN-1:0][REM_W-1:0]  rem_ff,  rem_in;
   rvg_pkg::lane_type                        lane_ff, lane_in;

   logic [REM_W-1:0]                trial;
   logic [rvg_pkg::NUM_CHAN-1:0]    take;

   always_comb begin
      trial   = REM_W'(in_den) << SHIFT;
      lane_in = in_lane;
      for (int c = 0; c < rvg_pkg::NUM_CHAN; c++) begin
         take[c]        = (in_rem[c] >= trial);
         rem_in[c]      = take[c] ? (in_rem[c] - trial) : in_rem[c];
         lane_in.quo[c] = {in_lane.quo[c][rvg_pkg::QUO_W-2:0], take[c]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         den_ff  <= in_den;
         rem_ff  <= rem_in;
         lane_ff <= lane_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_den   = den_ff;
   assign out_rem   = rem_ff;
   assign out_lane  = lane_ff;

endmodule
`default_nettype wire

// ----- rtl/rvg_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rvg_back: output stage of the gradient pipeline
// Applies the sign to each quotient, adds the top colour channel and packs
// the result into RGB565, or zero for a row outside the gradient.
// ----------------------------------------------------------------------------
module rvg_back (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 advance,
   input  wire                                 in_valid,
   input  wire rvg_pkg::lane_type              in_lane,
   output logic                                out_valid,
   output logic [rvg_pkg::COLOR_W-1:0]         out_color,
   output logic                                out_row_valid
);

   logic                              valid_ff;
   logic [rvg_pkg::COLOR_W-1:0]       color_ff, color_in;
   logic                              row_valid_ff;

   logic [rvg_pkg::NUM_CHAN-1:0][rvg_pkg::CHAN_W:0] chan;

   always_comb begin
      for (int c = 0; c < rvg_pkg::NUM_CHAN; c++) begin
         // The magnitude was divided, so the quotient truncates toward zero.
         if (in_lane.neg[c]) begin
            chan[c] = {1'b0, in_lane.base[c]} - {1'b0, in_lane.quo[c]};
         end else begin
            chan[c] = {1'b0, in_lane.base[c]} + {1'b0, in_lane.quo[c]};
         end
      end
      if (in_lane.row_ok) begin
         color_in = {chan[rvg_pkg::CH_RED][4:0]   & rvg_pkg::R_MASK,
                     chan[rvg_pkg::CH_GREEN][5:0] & rvg_pkg::G_MASK,
                     chan[rvg_pkg::CH_BLUE][4:0]  & rvg_pkg::B_MASK};
      end else begin
         color_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         color_ff     <= color_in;
         row_valid_ff <= in_lane.row_ok;
      end
   end

   assign out_valid     = valid_ff;
   assign out_color     = color_ff;
   assign out_row_valid = row_valid_ff;

endmodule
`default_nettype wire

// ----- rtl/rgb565_vertical_gradient_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rgb565_vertical_gradient_unit: RGB565 colour of one row of a vertical fill
// Linear interpolation between a top and a bottom colour, one row a request.
// ----------------------------------------------------------------------------
// Each request carries a row index and returns the interpolated RGB565 colour
// of that row together with a flag that says whether the row lies inside a
// nonempty gradient (rows outside it return colour zero). The block takes one
// request every cycle unless rsp_stall holds it: one input stage forms the
// products, a chain of six division cells each settles one quotient bit for
// all three channels, and one output register. The whole pipeline holds
// while a result waits on rsp_stall. The user must write configuration
// registers only while no request is in flight; the block never checks this.
module rgb565_vertical_gradient_unit #(
   parameter int MAX_ROWS = 1024
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 csr_write,
   input  wire [rvg_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire [rvg_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  wire                                 req_valid,
   output logic                                req_stall,
   input  wire [rvg_pkg::ROW_W-1:0]            req_row_index,
   output logic                                rsp_valid,
   input  wire                                 rsp_stall,
   output logic [rvg_pkg::COLOR_W-1:0]         rsp_row_color,
   output logic                                rsp_row_valid
);

   localparam int DEN_W     = $clog2(MAX_ROWS);
   localparam int REM_W     = DEN_W + rvg_pkg::QUO_W;
   localparam int NUM_CELLS = rvg_pkg::QUO_W;

   rvg_pkg::cfg_type  cfg_ff, cfg_in;
   logic              advance;

   logic                                     stg_valid [NUM_CELLS+1];
   logic [DEN_W-1:0]                         stg_den   [NUM_CELLS+1];
   logic [rvg_pkg::NUM_CHAN-1:0][REM_W-1:0]  stg_rem   [NUM_CELLS+1];
   rvg_pkg::lane_type                        stg_lane  [NUM_CELLS+1];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            rvg_pkg::CSR_TOP_COLOR:    cfg_in.top_color    = csr_wdata;
            rvg_pkg::CSR_BOTTOM_COLOR: cfg_in.bottom_color = csr_wdata;
            rvg_pkg::CSR_ROW_COUNT:    cfg_in.row_count    = csr_wdata[rvg_pkg::COUNT_W-1:0];
            rvg_pkg::CSR_FILL_WIDTH:   cfg_in.fill_width   = csr_wdata[rvg_pkg::COUNT_W-1:0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Every stage moves together unless the finished result is held back.
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   rvg_front #(
      .MAX_ROWS (MAX_ROWS),
      .DEN_W    (DEN_W),
      .REM_W    (REM_W)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .cfg       (cfg_ff),
      .in_valid  (req_valid),
      .in_row    (req_row_index),
      .out_valid (stg_valid[0]),
      .out_den   (stg_den[0]),
      .out_rem   (stg_rem[0]),
      .out_lane  (stg_lane[0])
   );

   for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
      rvg_div_cell #(
         .DEN_W (DEN_W),
         .REM_W (REM_W),
         .SHIFT (NUM_CELLS - 1 - k)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (stg_valid[k]),
         .in_den    (stg_den[k]),
         .in_rem    (stg_rem[k]),
         .in_lane   (stg_lane[k]),
         .out_valid (stg_valid[k+1]),
         .out_den   (stg_den[k+1]),
         .out_rem   (stg_rem[k+1]),
         .out_lane  (stg_lane[k+1])
      );
   end

   rvg_back u_back (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .in_valid      (stg_valid[NUM_CELLS]),
      .in_lane       (stg_lane[NUM_CELLS]),
      .out_valid     (rsp_valid),
      .out_color     (rsp_row_color),
      .out_row_valid (rsp_row_valid)
   );

endmodule
`default_nettype wire
